>>> rtl/core/sia_pkg.sv
`timescale 1ns / 1ps

package sia_pkg;

    localparam int DATA_W = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;
    localparam int STATUS_W = 2;
    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT    = 3'd0,
        KIND_LOOKUP    = 3'd1,
        KIND_RM_INDEX  = 3'd2,
        KIND_RM_FIRST  = 3'd3,
        KIND_RM_ALL    = 3'd4
    } kind_t;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_ACT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DEL_INDEX,
        CELL_DEL_MATCH
    } cell_op_t;

    typedef struct packed {
        logic     cmp;
        cell_op_t op;
    } cell_ctl_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [DATA_W-1:0]  value;
        logic [INDEX_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  removed_count;
    } rsp_t;

endpackage

>>> rtl/core/sorted_insertion_array.sv
`timescale 1ns / 1ps
// Sorted insertion array: ascending list of unsigned 32-bit values.
// Request channel (in_valid/in_stall/in_data) carries kind, value, index:
//   insert, lookup, remove at index, remove first match, remove all matches.
// Response channel (out_valid/out_stall/out_data) returns one item per
// request: read value, entry count, status, removed count.
// Storage is a row of DEPTH cells; each cell compares its entry against the
// key and moves data from its left or right neighbor in one step.
// Sequence: a request is taken in idle, then a compare state and an action
// state, then a done state in which the response register loads once the
// output slot is free; the next request waits for idle. Remove-all repeats
// compare/action once per deleted entry, plus a final pass with no match.
// Lookup uses a two-level select (groups of 16), first level registered.
// in_stall is high while a request is in work; a pending response does not
// block the next request, but a finished one waits while out_stall is high.
// Reset (rst_n low, async) empties the list and sets capacity to 256.
// cfg_we/cfg_data write the capacity limit; write only while idle.
module sorted_insertion_array #(
    parameter int DEPTH = 256
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sia_pkg::req_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sia_pkg::rsp_t                     out_data,
    input  logic                              cfg_we,
    input  logic [sia_pkg::COUNT_W-1:0]       cfg_data
);
    import sia_pkg::*;

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int GRP   = 16;
    localparam int NREAD = (DEPTH < 256) ? DEPTH : 256;
    localparam int NG    = (NREAD + GRP - 1) / GRP;

    state_t state_reg, state_next;

    logic [KIND_W-1:0]   kind_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [COUNT_W-1:0]  cap_reg;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0]   rd_reg, rd_next;
    logic                out_valid_reg;
    rsp_t                out_reg;

    logic [DATA_W-1:0] grp_reg [NG];
    logic [DATA_W-1:0] grp_pick;

    cell_ctl_t         ctl;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic              cell_lt   [DEPTH];
    logic [DEPTH-1:0]  hit_vec;
    logic              hit;
    logic              full;
    logic              in_range;
    logic              take_in;
    logic              slot_free;

    assign take_in   = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;
    assign hit       = |hit_vec;
    assign full      = (32'(count_reg) >= 32'(cap_reg)) || (32'(count_reg) >= DEPTH);
    assign in_range  = 32'(idx_reg) < 32'(count_reg);

    // cell row; cell 0 sees "all below are less", the top cell reads zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d, right_d;
        logic              left_l;
        if (i == 0)
        begin : g_lo
            assign left_d = '0;
            assign left_l = 1'b1;
        end
        else
        begin : g_mid
            assign left_d = cell_data[i-1];
            assign left_l = cell_lt[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_hi
            assign right_d = '0;
        end
        else
        begin : g_nhi
            assign right_d = cell_data[i+1];
        end
        sia_cell #(
            .POS (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .key        (key_reg),
            .index      (idx_reg),
            .left_data  (left_d),
            .left_lt    (left_l),
            .right_data (right_d),
            .data       (cell_data[i]),
            .lt         (cell_lt[i]),
            .first_hit  (hit_vec[i])
        );
    end

    // lookup, first level: one entry per group of 16, loaded in compare cycle
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CMP)
        begin
            for (int g = 0; g < NG; g++)
            begin
                grp_reg[g] <= '0;
                for (int j = 0; j < GRP; j++)
                begin
                    if ((g * GRP + j < DEPTH) && (idx_reg[3:0] == 4'(j)))
                        grp_reg[g] <= cell_data[(g * GRP + j) % DEPTH];
                end
            end
        end
    end

    // lookup, second level
    always_comb
    begin
        grp_pick = '0;
        for (int g = 0; g < NG; g++)
        begin
            if (idx_reg[7:4] == 4'(g))
                grp_pick = grp_reg[g];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_ACT;
            end
            ST_ACT:
            begin
                if (kind_reg == KIND_RM_ALL && hit)
                    state_next = ST_CMP;
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        ctl.cmp     = (state_reg == ST_CMP);
        ctl.op      = CELL_HOLD;
        count_next  = count_reg;
        rem_next    = rem_reg;
        status_next = status_reg;
        rd_next     = rd_reg;
        if (state_reg == ST_ACT)
        begin
            status_next = STATUS_OK;
            unique case (kind_reg)
                KIND_INSERT:
                begin
                    if (full)
                        status_next = STATUS_FULL;
                    else
                    begin
                        ctl.op     = CELL_INSERT;
                        count_next = CW'(count_reg + 1'b1);
                    end
                end
                KIND_LOOKUP:
                begin
                    if (in_range)
                        rd_next = grp_pick;
                    else
                        status_next = STATUS_RANGE;
                end
                KIND_RM_INDEX:
                begin
                    if (in_range)
                    begin
                        ctl.op     = CELL_DEL_INDEX;
                        count_next = CW'(count_reg - 1'b1);
                        rem_next   = COUNT_W'(1);
                    end
                    else
                        status_next = STATUS_RANGE;
                end
                KIND_RM_FIRST:
                begin
                    if (hit)
                    begin
                        ctl.op     = CELL_DEL_MATCH;
                        count_next = CW'(count_reg - 1'b1);
                        rem_next   = COUNT_W'(1);
                    end
                    else
                        status_next = STATUS_NOMATCH;
                end
                KIND_RM_ALL:
                begin
                    // one equal entry leaves per pass
                    if (hit)
                    begin
                        ctl.op     = CELL_DEL_MATCH;
                        count_next = CW'(count_reg - 1'b1);
                        rem_next   = COUNT_W'(rem_reg + 1'b1);
                    end
                    else if (rem_reg == '0)
                        status_next = STATUS_NOMATCH;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= COUNT_W'(256);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                cap_reg <= cfg_data;
            if (state_reg == ST_DONE && slot_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            kind_reg <= in_data.kind;
            key_reg  <= in_data.value;
            idx_reg  <= in_data.index;
            rem_reg  <= '0;
            rd_reg   <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            rd_reg  <= rd_next;
        end
        status_reg <= status_next;
        if (state_reg == ST_DONE && slot_free)
        begin
            out_reg.read_value    <= rd_reg;
            out_reg.entry_count   <= COUNT_W'(count_reg);
            out_reg.status        <= status_reg;
            out_reg.removed_count <= rem_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> rtl/core/sia_cell.sv
`timescale 1ns / 1ps

module sia_cell #(
    parameter int POS = 0,
    parameter int CW  = 9
) (
    input  logic                        clk,
    input  sia_pkg::cell_ctl_t          ctl,
    input  logic [CW-1:0]               count,
    input  logic [sia_pkg::DATA_W-1:0]  key,
    input  logic [sia_pkg::INDEX_W-1:0] index,
    input  logic [sia_pkg::DATA_W-1:0]  left_data,
    input  logic                        left_lt,
    input  logic [sia_pkg::DATA_W-1:0]  right_data,
    output logic [sia_pkg::DATA_W-1:0]  data,
    output logic                        lt,
    output logic                        first_hit
);
    import sia_pkg::*;

    logic [DATA_W-1:0] data_reg, data_next;
    logic              lt_reg, eq_reg;
    logic              valid;

    assign valid = 32'(POS) < 32'(count);

    // left_lt high means every cell below is less than the key
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_INSERT:
            begin
                if (!lt_reg)
                    data_next = left_lt ? key : left_data;
            end
            CELL_DEL_INDEX:
            begin
                if (32'(POS) >= 32'(index))
                    data_next = right_data;
            end
            CELL_DEL_MATCH:
            begin
                if (!lt_reg)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctl.cmp)
        begin
            lt_reg <= valid && (data_reg < key);
            eq_reg <= valid && (data_reg == key);
        end
    end

    assign data      = data_reg;
    assign lt        = lt_reg;
    assign first_hit = eq_reg && left_lt;

endmodule

>>> tb/tb_sorted_insertion_array.sv
`timescale 1ns / 1ps

// Testbench for sorted_insertion_array.
// A driver block feeds requests from a pending queue, a monitor block checks
// every response against a behavioral copy of the sorted list kept here.
// Capacity is rewritten between phases while the block is idle.
module tb_sorted_insertion_array;
    import sia_pkg::*;

    localparam int DEPTH_TB   = 256;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_WAIT = 1200;

    logic  clk;
    logic  rst_n;
    logic  in_valid;
    logic  in_stall;
    req_t  in_data;
    logic  out_valid;
    logic  out_stall;
    rsp_t  out_data;
    logic  cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    sorted_insertion_array #(.DEPTH(DEPTH_TB)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // Predictor state: sorted list, fill level, capacity register.
    logic [DATA_W-1:0]  list_mem [DEPTH_TB];
    int                 list_len;
    logic [COUNT_W-1:0] cap_reg;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];

    int  errors;
    int  n_sent;
    int  n_checked;
    int  idle_cycles;
    bit  idle_free;     // driver and receiver never idle while set
    bit  hold_rsp;      // receiver hold-off request
    int  hold_left;
    int  kind_seen [8];

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Work out the response of the list to one request; updates the model.
    function automatic rsp_t sorted_list_apply(req_t r);
        rsp_t res;
        int   cap;
        int   pos;
        int   w;
        res = '0;
        res.status = STATUS_OK;
        cap = (cap_reg > DEPTH_TB) ? DEPTH_TB : int'(cap_reg);
        case (r.kind)
            KIND_INSERT:
            begin
                if (list_len >= cap)
                    res.status = STATUS_FULL;
                else
                begin
                    pos = 0;
                    while (pos < list_len && list_mem[pos] < r.value)
                        pos++;
                    for (int k = list_len; k > pos; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[pos] = r.value;
                    list_len++;
                end
            end
            KIND_LOOKUP:
            begin
                if (r.index >= list_len)
                    res.status = STATUS_RANGE;
                else
                    res.read_value = list_mem[r.index];
            end
            KIND_RM_INDEX:
            begin
                if (r.index >= list_len)
                    res.status = STATUS_RANGE;
                else
                begin
                    for (int k = r.index; k + 1 < list_len; k++)
                        list_mem[k] = list_mem[k+1];
                    list_len--;
                    res.removed_count = 1;
                end
            end
            KIND_RM_FIRST, KIND_RM_ALL:
            begin
                w = 0;
                for (int k = 0; k < list_len; k++)
                begin
                    if (list_mem[k] == r.value &&
                        (r.kind == KIND_RM_ALL || res.removed_count == 0))
                        res.removed_count++;
                    else
                    begin
                        list_mem[w] = list_mem[k];
                        w++;
                    end
                end
                list_len = w;
                res.status = (res.removed_count != 0) ? STATUS_OK : STATUS_NOMATCH;
            end
            default: ;
        endcase
        res.entry_count = list_len[COUNT_W-1:0];
        return res;
    endfunction

    // Driver: present requests at the falling edge, advance on acceptance.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && in_stall)
            ;   // stalled request holds
        else if (pending_reqs.size() != 0 && (idle_free || $urandom_range(99) >= 23))
        begin
            in_valid <= 1'b1;
            in_data  <= pending_reqs[0];
        end
        else
            in_valid <= 1'b0;
    end

    // Prediction happens at the accepting edge so order matches the block.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            expected_rsps.push_back(sorted_list_apply(in_data));
            kind_seen[in_data.kind]++;
            void'(pending_reqs.pop_front());
            n_sent++;
        end
    end

    // Receiver stall: random, or a long counted hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_rsp && hold_left == 0)
        begin
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 1)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            hold_left <= 0;
            out_stall <= idle_free ? 1'b0 : ($urandom_range(99) < 23);
        end
    end

    // Monitor: compare each accepted response with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rsps.size() == 0)
            begin
                $error("response with nothing expected");
                errors++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsps.pop_front();
                n_checked++;
                if (out_data.read_value !== e.read_value)
                begin
                    $error("read_value exp %0h got %0h", e.read_value, out_data.read_value);
                    errors++;
                end
                if (out_data.entry_count !== e.entry_count)
                begin
                    $error("entry_count exp %0d got %0d", e.entry_count,
                           out_data.entry_count);
                    errors++;
                end
                if (out_data.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, out_data.status);
                    errors++;
                end
                if (out_data.removed_count !== e.removed_count)
                begin
                    $error("removed_count exp %0d got %0d", e.removed_count,
                           out_data.removed_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge clk)
    begin
        if ((rst_n && in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("tb_sorted_insertion_array: FAIL");
            $finish;
        end
    end

    function automatic req_t mk_req(kind_t k, logic [DATA_W-1:0] v, logic [INDEX_W-1:0] i);
        req_t r;
        r.kind  = k;
        r.value = v;
        r.index = i;
        return r;
    endfunction

    // Values from a small pool so matches and duplicates are common.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return {1'($urandom_range(1)), 31'h0} | 32'($urandom_range(15));
            default: return $urandom_range(40);
        endcase
    endfunction

    // Random request biased toward the current fill level.
    function automatic req_t rand_req(int fill_bias);
        req_t r;
        int   sel;
        sel = $urandom_range(99);
        r.value = pick_value();
        r.index = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(fill_bias));
        if (sel < 40)      r.kind = KIND_INSERT;
        else if (sel < 60) r.kind = KIND_LOOKUP;
        else if (sel < 75) r.kind = KIND_RM_INDEX;
        else if (sel < 87) r.kind = KIND_RM_FIRST;
        else if (sel < 96) r.kind = KIND_RM_ALL;
        else               r.kind = kind_t'(3'($urandom_range(5, 7)));
        return r;
    endfunction

    // Wait until the block has drained, then let it settle.
    task automatic wait_idle();
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_capacity(logic [COUNT_W-1:0] c);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= c;
        @(negedge clk);
        cfg_we   <= 1'b0;
        cap_reg  = c;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        hold_rsp  = 1'b0;
        idle_free = 1'b0;
        errors    = 0;
        n_sent    = 0;
        n_checked = 0;
        idle_cycles = 0;
        list_len  = 0;
        cap_reg   = 9'd256;
        foreach (kind_seen[i]) kind_seen[i] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-list cases, extremes, duplicates, unknown kinds.
        pending_reqs.push_back(mk_req(KIND_LOOKUP, '0, 8'd0));
        pending_reqs.push_back(mk_req(KIND_RM_INDEX, '0, 8'd255));
        pending_reqs.push_back(mk_req(KIND_RM_FIRST, 32'd5, 8'd0));
        pending_reqs.push_back(mk_req(KIND_RM_ALL, 32'd5, 8'd0));
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF));
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'd0, 8'd0));
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'd7, 8'd0));
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'd7, 8'd0));
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'd7, 8'd0));
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'h8000_0000, 8'd0));
        pending_reqs.push_back(mk_req(KIND_LOOKUP, '0, 8'd5));
        pending_reqs.push_back(mk_req(KIND_LOOKUP, '0, 8'd6));
        pending_reqs.push_back(mk_req(KIND_LOOKUP, '0, 8'd255));
        pending_reqs.push_back(mk_req(KIND_RM_FIRST, 32'd7, 8'd0));
        pending_reqs.push_back(mk_req(KIND_RM_ALL, 32'd7, 8'd0));
        pending_reqs.push_back(mk_req(KIND_RM_ALL, 32'd7, 8'd0));
        pending_reqs.push_back(mk_req(KIND_RM_INDEX, '0, 8'd0));
        pending_reqs.push_back(mk_req(kind_t'(3'd5), 32'hFFFF_FFFF, 8'hFF));
        pending_reqs.push_back(mk_req(kind_t'(3'd6), '0, 8'd0));
        pending_reqs.push_back(mk_req(kind_t'(3'd7), 32'h1234_5678, 8'd3));
        wait_idle();

        // Capacity at zero: every insert is refused.
        write_capacity(9'd0);
        pending_reqs.push_back(mk_req(KIND_INSERT, 32'd1, 8'd0));
        wait_idle();

        // Small capacity below the fill level, then at one, then fill a few.
        write_capacity(9'd1);
        for (int i = 0; i < 60; i++)
            pending_reqs.push_back(rand_req(3));
        wait_idle();

        write_capacity(9'd5);
        for (int i = 0; i < 200; i++)
            pending_reqs.push_back(rand_req(6));
        wait_idle();

        // Capacity beyond DEPTH is clamped; fill the list completely.
        write_capacity(9'd511);
        idle_free = 1'b1;
        for (int i = 0; i < 262; i++)
            pending_reqs.push_back(mk_req(KIND_INSERT, pick_value(), 8'($urandom)));
        wait_idle();
        idle_free = 1'b0;
        for (int i = 0; i < 300; i++)
            pending_reqs.push_back(rand_req(255));
        wait_idle();

        // Long receiver hold-off while requests keep coming.
        write_capacity(9'd256);
        for (int i = 0; i < 40; i++)
            pending_reqs.push_back(rand_req(40));
        hold_rsp = 1'b1;
        @(negedge clk);
        @(negedge clk);
        hold_rsp = 1'b0;
        wait_idle();

        write_capacity(9'd20);
        for (int i = 0; i < 340; i++)
            pending_reqs.push_back(rand_req(22));
        wait_idle();

        wait (expected_rsps.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Checked %0d of %0d requests: ins %0d look %0d rmi %0d rmf %0d rma %0d",
                 n_checked, n_sent, kind_seen[0], kind_seen[1], kind_seen[2],
                 kind_seen[3], kind_seen[4]);
        $display("Capacity settings 256, 0, 1, 5, 511, 20 with full list and hold-off");
        if (errors == 0 && expected_rsps.size() == 0)
            $display("tb_sorted_insertion_array: PASS");
        else
            $display("tb_sorted_insertion_array: FAIL");
        $finish;
    end
endmodule
